@@ hw/rtl/value_record_checker_crc32_defines.svh @@
// assertion macros for the record checker
// no dependencies; included by the top level
`ifndef VALUE_RECORD_CHECKER_CRC32_DEFINES_SVH
`define VALUE_RECORD_CHECKER_CRC32_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VRC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record checker assertion failed");

// next-cycle implication, disabled during reset
`define VRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record checker assertion failed");

`endif

@@ hw/rtl/vrc_pkg.sv @@
// constants, status codes and the byte-wide crc-32 update for the record checker
// no dependencies
package vrc_pkg;

  localparam int unsigned MAX_VALUE_BYTES_DEF = 4096;
  localparam int unsigned HDR_BYTES           = 20;
  localparam int unsigned VLEN_W              = 13;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // "MKV1"
  localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h4B, 8'h56, 8'h31};

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_CRC_MISMATCH = 3'd4
  } status_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/value_record_checker_crc32.sv @@
// Record checker: takes one byte of a header-framed record per cycle (20-byte header
// with magic "MKV1", version 1, flags, 64-bit value length and crc-32 of the value,
// then the value bytes). Each value byte is passed out as it arrives; the word for
// the byte marked last carries done_res and the check status. A byte is accepted
// every cycle while the result side keeps up; each result appears in the cycle after
// its byte is accepted, in a single output register, with the byte-wide crc-32
// update and header capture done combinationally between the input and that register.
// Depends on vrc_pkg and value_record_checker_crc32_defines.svh.
`include "value_record_checker_crc32_defines.svh"

module value_record_checker_crc32
  import vrc_pkg::*;
#(
  parameter int unsigned MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        file_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        value_byte,
  output logic              value_byte_valid,
  output logic              done_res,
  output logic [2:0]        check_status,
  output logic [VLEN_W-1:0] value_length
);

  localparam int unsigned LIMIT = HDR_BYTES + MAX_VALUE_BYTES;
  localparam int unsigned CNT_W = $clog2(LIMIT + 1);

  // record state
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             too_long_flag, too_long_flag_next;
  logic             magic_ok, magic_ok_next;
  logic [15:0]      version_field, version_field_next;
  logic [63:0]      length_field, length_field_next;
  logic [31:0]      stored_crc, stored_crc_next;
  logic [31:0]      running_crc, running_crc_next;

  // result register
  logic [7:0]        value_byte_next;
  logic              value_byte_valid_next;
  status_t           status, status_next;
  logic [VLEN_W-1:0] value_length_next;
  logic [CNT_W-1:0]  vlen;

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    byte_count_next       = byte_count;
    too_long_flag_next    = too_long_flag;
    magic_ok_next         = magic_ok;
    version_field_next    = version_field;
    length_field_next     = length_field;
    stored_crc_next       = stored_crc;
    running_crc_next      = running_crc;
    value_byte_valid_next = 1'b0;
    status_next           = ST_OK;

    if (byte_count >= CNT_W'(LIMIT)) begin
      too_long_flag_next = 1'b1;
    end else begin
      if (byte_count < CNT_W'(4)) begin
        if (file_byte != MAGIC[byte_count[1:0]]) magic_ok_next = 1'b0;
      end else if (byte_count < CNT_W'(6)) begin
        version_field_next[8*byte_count[0] +: 8] = file_byte;
      end else if (byte_count < CNT_W'(8)) begin
        // reserved flags, ignored
      end else if (byte_count < CNT_W'(16)) begin
        length_field_next[8*byte_count[2:0] +: 8] = file_byte;
      end else if (byte_count < CNT_W'(HDR_BYTES)) begin
        stored_crc_next[8*byte_count[1:0] +: 8] = file_byte;
      end else begin
        running_crc_next      = crc_byte(running_crc, file_byte);
        value_byte_valid_next = 1'b1;
      end
      byte_count_next = byte_count + CNT_W'(1);
    end

    vlen = (byte_count_next >= CNT_W'(HDR_BYTES)) ?
           (byte_count_next - CNT_W'(HDR_BYTES)) : '0;
    value_length_next = VLEN_W'(vlen);
    value_byte_next   = value_byte_valid_next ? file_byte : 8'd0;

    if (last_byte) begin
      if (too_long_flag_next || byte_count_next < CNT_W'(HDR_BYTES)) begin
        status_next = ST_BAD_SIZE;
      end else if (!magic_ok_next || version_field_next != 16'd1) begin
        status_next = ST_BAD_HEADER;
      end else if (length_field_next != 64'(vlen)) begin
        status_next = ST_LEN_MISMATCH;
      end else if ((running_crc_next ^ CRC_INIT) != stored_crc_next) begin
        status_next = ST_CRC_MISMATCH;
      end else begin
        status_next = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_count    <= '0;
      too_long_flag <= 1'b0;
      magic_ok      <= 1'b1;
      version_field <= '0;
      length_field  <= '0;
      stored_crc    <= '0;
      running_crc   <= CRC_INIT;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      too_long_flag <= too_long_flag_next;
      magic_ok      <= magic_ok_next;
      version_field <= version_field_next;
      length_field  <= length_field_next;
      stored_crc    <= stored_crc_next;
      running_crc   <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_byte       <= value_byte_next;
      value_byte_valid <= value_byte_valid_next;
      done_res         <= last_byte;
      status           <= status_next;
      value_length     <= value_length_next;
    end
  end

  assign check_status = status;

  `VRC_ASSERT_NOW(a_count_in_range, clk, rst, 1'b1, byte_count <= CNT_W'(LIMIT))
  `VRC_ASSERT_NEXT(a_restart_after_last, clk, rst, accept && last_byte,
                   byte_count == '0 && running_crc == CRC_INIT)
  `VRC_ASSERT_NOW(a_status_only_when_done, clk, rst, out_valid && !done_res,
                  status == ST_OK)
  `VRC_ASSERT_NOW(a_byte_zero_outside_value, clk, rst, out_valid && !value_byte_valid,
                  value_byte == 8'd0)

endmodule

@@ bench/vrc_word_checker.sv @@
// bench helpers and the result checker for value_record_checker_crc32
// holds a crc helper package and a module that predicts each result word and compares it
// depends on vrc_pkg
package vrc_bench_pkg;
  import vrc_pkg::*;

  typedef struct packed {
    logic [7:0]        vbyte;
    logic              vvalid;
    logic              done;
    vrc_pkg::status_t  status;
    logic [VLEN_W-1:0] vlen;
  } vrc_word_t;

  // bit-serial reflected crc-32 step over one byte
  function automatic logic [31:0] crc32_next(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction
endpackage

module vrc_word_checker
  import vrc_pkg::*;
  import vrc_bench_pkg::*;
#(
  parameter int unsigned MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        file_byte,
  input  logic              last_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        value_byte,
  input  logic              value_byte_valid,
  input  logic              done_res,
  input  logic [2:0]        check_status,
  input  logic [VLEN_W-1:0] value_length,
  output int                fail_count,
  output int                pending
);

  localparam int unsigned LIMIT = HDR_BYTES + MAX_VALUE_BYTES;

  // predicted copy of the block's record state
  int unsigned byte_pos;
  logic        over_limit;
  logic        magic_good;
  logic [15:0] hdr_version;
  logic [63:0] hdr_length;
  logic [31:0] hdr_crc;
  logic [31:0] value_crc;

  vrc_word_t expected_words[$];
  vrc_word_t want_w;

  function automatic void clear_record();
    byte_pos    = 0;
    over_limit  = 1'b0;
    magic_good  = 1'b1;
    hdr_version = '0;
    hdr_length  = '0;
    hdr_crc     = '0;
    value_crc   = CRC_INIT;
  endfunction

  function automatic vrc_word_t predict_word(logic [7:0] b, logic l);
    vrc_word_t   w;
    int unsigned vlen;
    w = '0;
    if (byte_pos >= LIMIT) begin
      over_limit = 1'b1;
    end else begin
      if (byte_pos < 4) begin
        if (b != MAGIC[byte_pos]) magic_good = 1'b0;
      end else if (byte_pos < 6) begin
        hdr_version[8*(byte_pos-4) +: 8] = b;
      end else if (byte_pos < 8) begin
        // flags are reserved
      end else if (byte_pos < 16) begin
        hdr_length[8*(byte_pos-8) +: 8] = b;
      end else if (byte_pos < HDR_BYTES) begin
        hdr_crc[8*(byte_pos-16) +: 8] = b;
      end else begin
        value_crc = crc32_next(value_crc, b);
        w.vvalid  = 1'b1;
        w.vbyte   = b;
      end
      byte_pos++;
    end
    vlen   = (byte_pos >= HDR_BYTES) ? byte_pos - HDR_BYTES : 0;
    w.vlen = vlen[VLEN_W-1:0];
    w.status = ST_OK;
    if (l) begin
      w.done = 1'b1;
      if (over_limit || byte_pos < HDR_BYTES) w.status = ST_BAD_SIZE;
      else if (!magic_good || hdr_version != 16'd1) w.status = ST_BAD_HEADER;
      else if (hdr_length != 64'(vlen)) w.status = ST_LEN_MISMATCH;
      else if ((value_crc ^ CRC_INIT) != hdr_crc) w.status = ST_CRC_MISMATCH;
      clear_record();
    end
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_record();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words = {expected_words, predict_word(file_byte, last_byte)};
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected");
          fail_count++;
        end else begin
          want_w = expected_words.pop_front();
          check_field("value_byte", 32'(want_w.vbyte), 32'(value_byte));
          check_field("value_byte_valid", 32'(want_w.vvalid), 32'(value_byte_valid));
          check_field("done_res", 32'(want_w.done), 32'(done_res));
          check_field("check_status", 32'(want_w.status), 32'(check_status));
          check_field("value_length", 32'(want_w.vlen), 32'(value_length));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ bench/tb.sv @@
// top of the bench for value_record_checker_crc32: clock, reset, record stimulus, verdict
// depends on vrc_pkg, vrc_bench_pkg and vrc_word_checker
module tb;
  import vrc_pkg::*;
  import vrc_bench_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 250000;

  typedef enum int {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_VERSION,
    REC_LEN_MISMATCH,
    REC_CRC_MISMATCH,
    REC_SHORT,
    REC_NOISE
  } rec_kind_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        file_byte = 8'd0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        value_byte;
  logic              value_byte_valid;
  logic              done_res;
  logic [2:0]        check_status;
  logic [VLEN_W-1:0] value_length;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle   = 0;
  int unsigned recv_idle   = 0;
  logic [7:0]  rec_bytes[$];

  always #4 clk = ~clk;

  value_record_checker_crc32 #(.MAX_VALUE_BYTES(MAX_VALUE_BYTES_DEF)) dut (
    .clk, .rst, .in_valid, .in_ready, .file_byte, .last_byte,
    .out_valid, .out_ready, .value_byte, .value_byte_valid,
    .done_res, .check_status, .value_length
  );

  vrc_word_checker #(.MAX_VALUE_BYTES(MAX_VALUE_BYTES_DEF)) chk (
    .clk, .rst, .in_valid, .in_ready, .file_byte, .last_byte,
    .out_valid, .out_ready, .value_byte, .value_byte_valid,
    .done_res, .check_status, .value_length,
    .fail_count, .pending
  );

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic push_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    file_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_bytes.size(); i++) push_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  task automatic build_record(input rec_kind_t kind, input int unsigned n);
    logic [15:0] ver;
    logic [15:0] flags;
    logic [63:0] len;
    logic [31:0] crc;
    logic [7:0]  vals[$];
    logic [7:0]  b;
    int unsigned fill;
    int unsigned cnt;
    rec_bytes.delete();
    if (kind == REC_SHORT || kind == REC_NOISE) begin
      cnt = (kind == REC_SHORT) ? $urandom_range(1, 19) : $urandom_range(1, 60);
      for (int i = 0; i < cnt; i++) begin
        // a magic prefix now and then so the header path gets exercised
        b = (i < 4 && $urandom_range(0, 1)) ? MAGIC[i] : 8'($urandom);
        rec_bytes = {rec_bytes, b};
      end
      return;
    end
    fill  = $urandom_range(0, 9);
    ver   = 16'd1;
    flags = 16'($urandom);
    crc   = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      vals = {vals, b};
      crc = crc32_next(crc, b);
    end
    crc = crc ^ CRC_INIT;
    len = 64'(n);
    case (kind)
      REC_BAD_VERSION: begin
        case ($urandom_range(0, 2))
          0: ver = 16'h0100;
          1: ver = 16'h0000;
          default: begin
            ver = 16'($urandom);
            if (ver == 16'd1) ver = 16'hFFFF;
          end
        endcase
      end
      REC_LEN_MISMATCH: begin
        case ($urandom_range(0, 2))
          0: len = 64'(n) + 64'd1;
          1: len = {$urandom, $urandom};
          default: len = 64'(n) | (64'd1 << $urandom_range(13, 63));
        endcase
        if (len == 64'(n)) len = ~len;
      end
      REC_CRC_MISMATCH: crc = crc ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    for (int k = 0; k < 4; k++) rec_bytes = {rec_bytes, MAGIC[k]};
    rec_bytes = {rec_bytes, ver[7:0]};
    rec_bytes = {rec_bytes, ver[15:8]};
    rec_bytes = {rec_bytes, flags[7:0]};
    rec_bytes = {rec_bytes, flags[15:8]};
    for (int k = 0; k < 8; k++) rec_bytes = {rec_bytes, len[8*k +: 8]};
    for (int k = 0; k < 4; k++) rec_bytes = {rec_bytes, crc[8*k +: 8]};
    foreach (vals[i]) rec_bytes = {rec_bytes, vals[i]};
    if (kind == REC_BAD_MAGIC) begin
      cnt = $urandom_range(0, 3);
      rec_bytes[cnt] = rec_bytes[cnt] ^ 8'($urandom_range(1, 255));
    end
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned r;
    int unsigned n;
    rec_kind_t   kind;
    rand_items = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 22;
    recv_idle = 72;
    // one-byte record, all ones
    rec_bytes = '{8'hFF};
    send_record();
    // three-byte record, never reaches the end of the header
    rec_bytes = '{8'h00, 8'h4D, 8'h80};
    send_record();
    // header only, empty value, crc of nothing
    build_record(REC_GOOD, 0);
    send_record();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 22; recv_idle = 72; end
        1: begin send_idle = 72; recv_idle = 22; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase == 2) begin
        // value exactly at the limit, then a record running past it
        build_record(REC_GOOD, MAX_VALUE_BYTES_DEF);
        send_record();
        build_record(REC_GOOD, MAX_VALUE_BYTES_DEF);
        repeat ($urandom_range(1, 3)) rec_bytes = {rec_bytes, 8'($urandom)};
        send_record();
      end
      while (rand_items < (phase + 1) * RANDOM_ITEMS / 3) begin
        r = $urandom_range(0, 99);
        if (r < 45) kind = REC_GOOD;
        else if (r < 55) kind = REC_CRC_MISMATCH;
        else if (r < 65) kind = REC_LEN_MISMATCH;
        else if (r < 73) kind = REC_BAD_VERSION;
        else if (r < 81) kind = REC_BAD_MAGIC;
        else if (r < 90) kind = REC_SHORT;
        else kind = REC_NOISE;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        build_record(kind, n);
        send_record();
        rand_items += rec_bytes.size();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
